@@ hdl/eebp_pkg.sv @@
package eebp_pkg;

    localparam int IN_CH       = 4;
    localparam int SAMPLE_W    = 24;
    localparam int COMP_W      = 16;
    localparam int POW_W       = 8;
    localparam int FOCUS_W     = 7;
    localparam int CUR_W       = 8;
    localparam int QUOT_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 112;
    localparam int PROD_W      = 48;
    localparam int RECIP3_SH   = 25;

    localparam logic [SAMPLE_W-1:0] RECIP3        = 24'hAAAAAB;
    localparam logic [FOCUS_W-1:0]  FOCUS_PCT     = 7'd100;
    localparam logic [FOCUS_W-1:0]  FOCUS_DEFAULT = 7'd50;

    localparam int STAT_STIM   = 0;
    localparam int STAT_SAFE   = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DRAIN,
        ST_TOTAL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        SEL_DELTA,
        SEL_THETA,
        SEL_ALPHA,
        SEL_BETA,
        SEL_FOCUS
    } band_sel_t;

    typedef struct packed {
        logic      load;
        logic      acc_step;
        logic      ld_total;
        logic      div_start;
        band_sel_t div_sel;
        logic      out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last_ch;
        logic div_done;
    } dp_status_t;

endpackage

@@ hdl/eeg_band_power_estimator.sv @@
// EEG band power estimator.
// Slave channel (s_): one transaction is one frame of four signed 24-bit samples,
// the drive current and two status flags. Master channel (m_): one transaction
// per frame with the compressed samples, four band powers, the focus score, the
// echoed current and the status flags.
// A frame is processed one channel per cycle through a registered abs/multiply
// stage, then five quotients go through one shared 8-step restoring divider.
// After a frame is accepted, the channel walk, the pipeline drain, the total
// and the five divisions run in turn, and then the result load raises m_tvalid.
// A new frame is taken only once the last one is loaded for output; s_tready is
// high only while no frame is in work.
// A finished result waits in the output register; the next frame is accepted
// and processed meanwhile, and only its final load waits for m_tready.
// Reset (aresetn low, synchronous): drops any frame in work, clears m_tvalid
// and sets the stored previous samples to zero.
module eeg_band_power_estimator #(
    parameter int CHANNELS = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sample_ch0, sample_ch1, sample_ch2, sample_ch3, drive_current_tenths
    input  logic [eebp_pkg::S_TDATA_W-1:0] s_tdata,
    // stim_on, safety_good
    input  logic [eebp_pkg::STATUS_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // comp_ch0..comp_ch3, delta_pwr, theta_pwr, alpha_pwr, beta_pwr,
    // focus_pct, current_echo, zero pad
    output logic [eebp_pkg::M_TDATA_W-1:0] m_tdata,
    // status_bits
    output logic [eebp_pkg::STATUS_W-1:0]  m_tuser
);

    eebp_pkg::dp_cmd_t    cmd;
    eebp_pkg::dp_status_t status;

    eebp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    eebp_datapath #(
        .CHANNELS(CHANNELS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_tdata),
        .in_user  (s_tuser),
        .out_data (m_tdata),
        .out_user (m_tuser)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("frame accepted while another is in work");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("result raised without load");

    a_focus_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[102:96] <= eebp_pkg::FOCUS_PCT))
        else $error("focus score above 100");
`endif

endmodule

@@ hdl/eebp_div.sv @@
module eebp_div #(
    parameter int DW = 37,
    parameter int NW = 29
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [DW-1:0]              dividend,
    input  logic [NW-1:0]              divisor,
    output logic [eebp_pkg::QUOT_W-1:0] quotient,
    output logic                       done
);

    localparam int CNT_W = $clog2(eebp_pkg::QUOT_W);

    logic [DW-1:0]               rem_reg, rem_next;
    logic [DW-1:0]               dsh_reg, dsh_next;
    logic [eebp_pkg::QUOT_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        fits;

    assign fits = (rem_reg >= dsh_reg);

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dsh_next  = DW'(divisor) << (eebp_pkg::QUOT_W - 1);
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[eebp_pkg::QUOT_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(eebp_pkg::QUOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

@@ hdl/eebp_datapath.sv @@
module eebp_datapath #(
    parameter int CHANNELS = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  eebp_pkg::dp_cmd_t                cmd,
    output eebp_pkg::dp_status_t             status,
    input  logic [eebp_pkg::S_TDATA_W-1:0]   in_data,
    input  logic [eebp_pkg::STATUS_W-1:0]    in_user,
    output logic [eebp_pkg::M_TDATA_W-1:0]   out_data,
    output logic [eebp_pkg::STATUS_W-1:0]    out_user
);

    localparam int SW = eebp_pkg::SAMPLE_W;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TW = 27 + $clog2(CHANNELS);
    localparam int DW = TW + eebp_pkg::QUOT_W;
    localparam int PW = eebp_pkg::POW_W;

    logic signed [SW-1:0]             frame_reg [eebp_pkg::IN_CH];
    logic signed [SW-1:0]             prev_reg  [CHANNELS];
    logic signed [SW-1:0]             chan_x    [CHANNELS];
    logic [eebp_pkg::COMP_W-1:0]      comp_reg  [eebp_pkg::IN_CH];
    logic [eebp_pkg::CUR_W-1:0]       cur_reg;
    logic [eebp_pkg::STATUS_W-1:0]    flags_reg;

    logic [CW-1:0]                    ch_reg;
    logic signed [SW-1:0]             x_sel, prev_sel;
    logic signed [SW:0]               diff;
    logic [SW:0]                      diff_mag;
    logic [SW-1:0]                    ax, ad;
    logic [SW-1:0]                    ax_reg, ad_reg;
    logic [eebp_pkg::PROD_W-1:0]      prod_reg;
    logic                             pipe_vld_reg;

    logic [TW-1:0]                    delta_reg, theta_reg, alpha_reg, beta_reg;
    logic [TW-1:0]                    total_reg, total_sum;

    logic [PW-1:0]                    dpow_reg, tpow_reg, apow_reg, bpow_reg;
    logic [eebp_pkg::FOCUS_W-1:0]     focus_reg;
    logic [PW:0]                      ab_sum;
    logic [14:0]                      bp100;
    logic [TW-1:0]                    part;
    logic [DW-1:0]                    div_num;
    logic [TW-1:0]                    div_den;
    logic [eebp_pkg::QUOT_W-1:0]      quot;
    logic                             div_done;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
        if (i < eebp_pkg::IN_CH) begin : g_in
            assign chan_x[i] = frame_reg[i];
        end else begin : g_zero
            assign chan_x[i] = '0;
        end
    end

    assign x_sel    = chan_x[ch_reg];
    assign prev_sel = prev_reg[ch_reg];
    assign ax       = x_sel[SW-1] ? (~x_sel + 1'b1) : x_sel;
    assign diff     = {x_sel[SW-1], x_sel} - {prev_sel[SW-1], prev_sel};
    assign diff_mag = diff[SW] ? (~diff + 1'b1) : diff;
    assign ad       = diff_mag[SW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < eebp_pkg::IN_CH; i++) begin
                frame_reg[i] <= in_data[i*SW +: SW];
                comp_reg[i]  <= in_data[i*SW + 8 +: eebp_pkg::COMP_W];
            end
            cur_reg   <= in_data[eebp_pkg::IN_CH*SW +: eebp_pkg::CUR_W];
            flags_reg <= in_user;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                prev_reg[i] <= '0;
            end
            ch_reg       <= '0;
            pipe_vld_reg <= 1'b0;
        end else begin
            pipe_vld_reg <= cmd.acc_step;
            if (cmd.load) begin
                ch_reg <= '0;
            end else if (cmd.acc_step) begin
                prev_reg[ch_reg] <= x_sel;
                ch_reg           <= ch_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc_step) begin
            ax_reg   <= ax;
            ad_reg   <= ad;
            prod_reg <= ax * eebp_pkg::RECIP3;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            delta_reg <= '0;
            theta_reg <= '0;
            alpha_reg <= '0;
            beta_reg  <= '0;
        end else if (pipe_vld_reg) begin
            delta_reg <= delta_reg + TW'(ax_reg);
            theta_reg <= theta_reg + TW'(ax_reg >> 1);
            alpha_reg <= alpha_reg + TW'(prod_reg[eebp_pkg::PROD_W-1:eebp_pkg::RECIP3_SH])
                         + TW'(ad_reg);
            beta_reg  <= beta_reg + TW'(ad_reg);
        end
    end

    assign total_sum = delta_reg + theta_reg + alpha_reg + beta_reg;

    always_ff @(posedge aclk) begin
        if (cmd.ld_total) begin
            total_reg <= (total_sum == '0) ? TW'(1) : total_sum;
        end
    end

    assign ab_sum = {1'b0, apow_reg} + {1'b0, bpow_reg};
    assign bp100  = 15'(bpow_reg) * 15'(eebp_pkg::FOCUS_PCT);

    always_comb begin
        case (cmd.div_sel)
            eebp_pkg::SEL_DELTA: part = delta_reg;
            eebp_pkg::SEL_THETA: part = theta_reg;
            eebp_pkg::SEL_ALPHA: part = alpha_reg;
            eebp_pkg::SEL_BETA:  part = beta_reg;
            default:             part = '0;
        endcase
        if (cmd.div_sel == eebp_pkg::SEL_FOCUS) begin
            div_num = DW'(bp100);
            div_den = TW'(ab_sum);
        end else begin
            div_num = (DW'(part) << 8) - DW'(part);
            div_den = total_reg;
        end
    end

    eebp_div #(
        .DW(DW),
        .NW(TW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (quot),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (div_done) begin
            case (cmd.div_sel)
                eebp_pkg::SEL_DELTA: dpow_reg <= quot;
                eebp_pkg::SEL_THETA: tpow_reg <= quot;
                eebp_pkg::SEL_ALPHA: apow_reg <= quot;
                eebp_pkg::SEL_BETA:  bpow_reg <= quot;
                eebp_pkg::SEL_FOCUS: focus_reg <= (ab_sum == '0) ? eebp_pkg::FOCUS_DEFAULT
                                                                 : quot[eebp_pkg::FOCUS_W-1:0];
                default:             dpow_reg <= dpow_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data <= {1'b0, cur_reg, focus_reg, bpow_reg, apow_reg, tpow_reg, dpow_reg,
                         comp_reg[3], comp_reg[2], comp_reg[1], comp_reg[0]};
            out_user <= flags_reg;
        end
    end

    assign status.last_ch  = (ch_reg == CW'(CHANNELS - 1));
    assign status.div_done = div_done;

endmodule

@@ hdl/eebp_ctrl.sv @@
module eebp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output eebp_pkg::dp_cmd_t    cmd,
    input  eebp_pkg::dp_status_t status
);

    eebp_pkg::state_t    state_reg, state_next;
    eebp_pkg::band_sel_t sel_reg, sel_next;
    logic                out_vld_reg, out_vld_next;
    logic                out_free;

    assign out_free = !out_vld_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        case (state_reg)
            eebp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = eebp_pkg::ST_ACC;
                end
            end
            eebp_pkg::ST_ACC: begin
                if (status.last_ch) begin
                    state_next = eebp_pkg::ST_DRAIN;
                end
            end
            eebp_pkg::ST_DRAIN: begin
                state_next = eebp_pkg::ST_TOTAL;
            end
            eebp_pkg::ST_TOTAL: begin
                sel_next   = eebp_pkg::SEL_DELTA;
                state_next = eebp_pkg::ST_DIV_START;
            end
            eebp_pkg::ST_DIV_START: begin
                state_next = eebp_pkg::ST_DIV_WAIT;
            end
            eebp_pkg::ST_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = eebp_pkg::ST_DIV_START;
                    case (sel_reg)
                        eebp_pkg::SEL_DELTA: sel_next = eebp_pkg::SEL_THETA;
                        eebp_pkg::SEL_THETA: sel_next = eebp_pkg::SEL_ALPHA;
                        eebp_pkg::SEL_ALPHA: sel_next = eebp_pkg::SEL_BETA;
                        eebp_pkg::SEL_BETA:  sel_next = eebp_pkg::SEL_FOCUS;
                        default:             state_next = eebp_pkg::ST_OUT;
                    endcase
                end
            end
            eebp_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = eebp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = eebp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.div_sel  = sel_reg;
        s_tready     = 1'b0;
        out_vld_next = out_vld_reg && !m_tready;
        case (state_reg)
            eebp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            eebp_pkg::ST_ACC: begin
                cmd.acc_step = 1'b1;
            end
            eebp_pkg::ST_TOTAL: begin
                cmd.ld_total = 1'b1;
            end
            eebp_pkg::ST_DIV_START: begin
                cmd.div_start = 1'b1;
            end
            eebp_pkg::ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    out_vld_next = 1'b1;
                end
            end
            default: begin
                cmd.load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= eebp_pkg::ST_IDLE;
            sel_reg     <= eebp_pkg::SEL_DELTA;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_tvalid = out_vld_reg;

endmodule
